// ===== rtl/qscl_pkg.sv =====
// qscl_pkg: shared types, character codes and a hex-digit helper for the quoted-string lexer
// no dependencies; imported by every module of the block

package qscl_pkg;

    localparam int LINE_BITS_DEFAULT = 16;
    localparam int RES_DEPTH         = 4;

    typedef enum logic [2:0] {
        KIND_OPEN    = 3'd0,
        KIND_CLOSE   = 3'd1,
        KIND_NEWLINE = 3'd2,
        KIND_BYTE    = 3'd3,
        KIND_STREND  = 3'd4,
        KIND_ERROR   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_NEWLINE  = 2'd1,
        ERR_UNCLOSED = 2'd2
    } err_code_t;

    typedef enum logic [2:0] {
        MODE_OUT  = 3'd0,
        MODE_STR  = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX1 = 3'd3,
        MODE_HEX2 = 3'd4,
        MODE_SKIP = 3'd5
    } mode_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_N  = 8'h6e;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_X  = 8'h78;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        err_code_t  err_code;
        logic [15:0] line_number;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } lex_res_t;

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = 4'(c - 8'h37);
        end
        return d;
    endfunction

endpackage

// ===== rtl/qscl_lexer.sv =====
// qscl_lexer: lexer state and per-byte decode into up to two results
// depends on qscl_pkg

module qscl_lexer #(
    parameter int LINE_BITS = qscl_pkg::LINE_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  qscl_pkg::in_item_t cur,
    output qscl_pkg::lex_res_t res
);
    import qscl_pkg::*;

    mode_t                mode_reg, mode_next;
    logic [3:0]           hex_reg, hex_next;
    logic [LINE_BITS-1:0] line_reg, line_next;

    logic                 p_valid;
    out_item_t            p_item;
    logic                 e_valid;
    out_item_t            e_item;
    mode_t                mode_mid;
    logic [LINE_BITS-1:0] line_mid;
    logic [7:0]           c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OUT;
            hex_reg  <= 4'd0;
            line_reg <= LINE_BITS'(1);
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
            line_reg <= line_next;
        end
    end

    always_comb
    begin
        c        = cur.in_byte;
        mode_mid = mode_reg;
        hex_next = hex_reg;
        line_mid = line_reg;
        p_valid  = 1'b0;
        p_item   = '{kind: KIND_BYTE, value: 8'd0, err_code: ERR_NONE,
                     line_number: 16'd0, last_of_run: 1'b0};

        unique case (mode_reg)
            MODE_OUT:
            begin
                if (c == CH_QUOTE)
                begin
                    mode_mid = MODE_STR;
                end
                else if (c == CH_LBRACE)
                begin
                    p_valid     = 1'b1;
                    p_item.kind = KIND_OPEN;
                end
                else if (c == CH_RBRACE)
                begin
                    p_valid     = 1'b1;
                    p_item.kind = KIND_CLOSE;
                end
                else if (c == CH_LF)
                begin
                    if (line_reg != '1)
                    begin
                        line_mid = line_reg + LINE_BITS'(1);
                    end
                    p_valid     = 1'b1;
                    p_item.kind = KIND_NEWLINE;
                end
            end
            MODE_STR:
            begin
                if (c == CH_BSLASH)
                begin
                    mode_mid = MODE_ESC;
                end
                else if (c == CH_QUOTE)
                begin
                    p_valid     = 1'b1;
                    p_item.kind = KIND_STREND;
                    mode_mid    = MODE_OUT;
                end
                else if (c == CH_LF || c == CH_CR)
                begin
                    p_valid         = 1'b1;
                    p_item.kind     = KIND_ERROR;
                    p_item.err_code = ERR_NEWLINE;
                    mode_mid        = MODE_SKIP;
                end
                else
                begin
                    p_valid      = 1'b1;
                    p_item.value = c;
                end
            end
            MODE_ESC:
            begin
                mode_mid = MODE_STR;
                p_valid  = 1'b1;
                if (c == CH_LOW_T)
                begin
                    p_item.value = CH_TAB;
                end
                else if (c == CH_LOW_N)
                begin
                    p_item.value = CH_LF;
                end
                else if (c == CH_LOW_R)
                begin
                    p_item.value = CH_CR;
                end
                else if (c == CH_LOW_B)
                begin
                    p_item.value = CH_BS;
                end
                else if (c == CH_LOW_X)
                begin
                    p_valid  = 1'b0;
                    mode_mid = MODE_HEX1;
                end
                else
                begin
                    p_item.value = c;
                end
            end
            MODE_HEX1:
            begin
                hex_next = hex_digit(c);
                mode_mid = MODE_HEX2;
            end
            MODE_HEX2:
            begin
                p_valid      = 1'b1;
                p_item.value = {hex_reg, hex_digit(c)};
                mode_mid     = MODE_STR;
            end
            MODE_SKIP:
            begin
            end
            default:
            begin
            end
        endcase

        p_item.line_number = 16'(line_mid);

        e_valid = 1'b0;
        e_item  = '{kind: KIND_ERROR, value: 8'd0, err_code: ERR_UNCLOSED,
                    line_number: 16'(line_mid), last_of_run: 1'b1};
        mode_next = mode_mid;
        line_next = line_mid;
        if (cur.end_of_buffer)
        begin
            e_valid   = (mode_mid == MODE_STR) || (mode_mid == MODE_ESC) ||
                        (mode_mid == MODE_HEX1) || (mode_mid == MODE_HEX2);
            mode_next = MODE_OUT;
            hex_next  = 4'd0;
            line_next = LINE_BITS'(1);
        end

        p_item.last_of_run = !e_valid;
        res.count  = {1'b0, p_valid} + {1'b0, e_valid};
        res.first  = p_valid ? p_item : e_item;
        res.second = e_item;
    end

endmodule

// ===== rtl/qscl_res_fifo.sv =====
// qscl_res_fifo: small result queue taking up to two results per cycle
// depends on qscl_pkg

module qscl_res_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  qscl_pkg::lex_res_t  res,
    output logic                room,
    output logic                result_valid,
    input  logic                result_ready,
    output qscl_pkg::out_item_t result
);
    import qscl_pkg::*;

    localparam int PTR_BITS = $clog2(RES_DEPTH);
    localparam int CNT_BITS = $clog2(RES_DEPTH + 1);

    out_item_t             mem [RES_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [1:0]            n_push;
    logic                  pop;

    assign n_push       = push ? res.count : 2'd0;
    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != '0);
    assign result       = mem[rd_ptr_reg];
    assign room         = (count_reg <= CNT_BITS'(RES_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(n_push);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(n_push) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            mem[wr_ptr_reg] <= res.first;
        end
        if (n_push == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_BITS'(1)] <= res.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/quoted_string_config_lexer.sv =====
// Quoted-string lexer for brace-structured configuration text. One text byte
// is taken per cycle on the item channel while the input register can advance;
// it passes an input register and combinational decode against the lexer
// state and lands in a four-entry result queue; each byte leaves at most two
// results. The input register advances while the queue holds two results or
// fewer, so the sustained rate is one byte per cycle as long as results are
// drained at least as fast as they are made. Line numbers count from 1 and
// restart at each buffer end.
// depends on qscl_pkg, qscl_lexer, qscl_res_fifo

module quoted_string_config_lexer #(
    parameter int LINE_BITS = qscl_pkg::LINE_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  qscl_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output qscl_pkg::out_item_t result
);
    import qscl_pkg::*;

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      room;
    logic      advance;
    lex_res_t  res;

    assign advance       = in_valid_reg && room;
    assign item_ready    = !in_valid_reg || advance;
    assign in_valid_next = (item_valid && item_ready) ? 1'b1 :
                           (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_item_reg <= item;
        end
    end

    qscl_lexer #(
        .LINE_BITS(LINE_BITS)
    ) u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cur     (in_item_reg),
        .res     (res)
    );

    qscl_res_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (advance),
        .res          (res),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== rtl/qscl_checker.sv =====
// qscl_checker: port-level checks for the quoted-string lexer, bound to the top level
// depends on qscl_pkg and quoted_string_config_lexer

module qscl_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_ready,
    input qscl_pkg::out_item_t result
);
    import qscl_pkg::*;

    // a stalled result transfer holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_value_only_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind != KIND_BYTE |-> result.value == 8'd0)
        else $error("value set on a non-byte result");

    a_err_only_errors: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.kind == KIND_ERROR) == (result.err_code != ERR_NONE)))
        else $error("error code does not match kind");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.line_number != 16'd0)
        else $error("line number is zero");

    // nothing comes out before the first byte can have been decoded
    a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !result_valid ##1 !result_valid)
        else $error("result shown too early after reset");

endmodule

bind quoted_string_config_lexer qscl_checker u_qscl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// ===== dv/tb_quoted_string_config_lexer.sv =====
// tb_quoted_string_config_lexer: self-checking testbench for the quoted-string lexer
// directed token, escape, error and line-count tests, then random config text
// depends on qscl_pkg and quoted_string_config_lexer

module tb_quoted_string_config_lexer;

    import qscl_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    in_item_t  item;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int fails         = 0;
    int bytes_sent    = 0;
    int buffers_sent  = 0;
    int tokens_seen   = 0;
    int lex_errs_seen = 0;

    out_item_t   exp_tokens[$];
    mode_t       lex_mode = MODE_OUT;
    logic [3:0]  hex_hi   = 4'd0;
    logic [15:0] line_cnt = 16'd1;

    quoted_string_config_lexer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return c[3:0];
        end
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
        begin
            return c[3:0] + 4'd9;
        end
        return 4'd0;
    endfunction

    function automatic out_item_t make_token(input kind_t k, input logic [7:0] v,
                                             input err_code_t e);
        out_item_t t;
        t.kind        = k;
        t.value       = v;
        t.err_code    = e;
        t.line_number = line_cnt;
        t.last_of_run = 1'b0;
        return t;
    endfunction

    function automatic void predict_tokens(input in_item_t it);
        out_item_t  tok [2];
        int         n;
        logic [7:0] c;
        n = 0;
        c = it.in_byte;
        case (lex_mode)
            MODE_OUT:
            begin
                if (c == CH_QUOTE)
                begin
                    lex_mode = MODE_STR;
                end
                else if (c == CH_LBRACE)
                begin
                    tok[n++] = make_token(KIND_OPEN, 8'h00, ERR_NONE);
                end
                else if (c == CH_RBRACE)
                begin
                    tok[n++] = make_token(KIND_CLOSE, 8'h00, ERR_NONE);
                end
                else if (c == CH_LF)
                begin
                    if (line_cnt != 16'hffff)
                    begin
                        line_cnt = line_cnt + 16'd1;
                    end
                    tok[n++] = make_token(KIND_NEWLINE, 8'h00, ERR_NONE);
                end
            end
            MODE_STR:
            begin
                if (c == CH_BSLASH)
                begin
                    lex_mode = MODE_ESC;
                end
                else if (c == CH_QUOTE)
                begin
                    tok[n++] = make_token(KIND_STREND, 8'h00, ERR_NONE);
                    lex_mode = MODE_OUT;
                end
                else if (c == CH_LF || c == CH_CR)
                begin
                    tok[n++] = make_token(KIND_ERROR, 8'h00, ERR_NEWLINE);
                    lex_mode = MODE_SKIP;
                end
                else
                begin
                    tok[n++] = make_token(KIND_BYTE, c, ERR_NONE);
                end
            end
            MODE_ESC:
            begin
                lex_mode = MODE_STR;
                case (c)
                    CH_LOW_T: tok[n++] = make_token(KIND_BYTE, CH_TAB, ERR_NONE);
                    CH_LOW_N: tok[n++] = make_token(KIND_BYTE, CH_LF, ERR_NONE);
                    CH_LOW_R: tok[n++] = make_token(KIND_BYTE, CH_CR, ERR_NONE);
                    CH_LOW_B: tok[n++] = make_token(KIND_BYTE, CH_BS, ERR_NONE);
                    CH_LOW_X: lex_mode = MODE_HEX1;
                    default:  tok[n++] = make_token(KIND_BYTE, c, ERR_NONE);
                endcase
            end
            MODE_HEX1:
            begin
                hex_hi   = nibble_of(c);
                lex_mode = MODE_HEX2;
            end
            MODE_HEX2:
            begin
                tok[n++] = make_token(KIND_BYTE, {hex_hi, nibble_of(c)}, ERR_NONE);
                lex_mode = MODE_STR;
            end
            default:
            begin
            end
        endcase
        if (it.end_of_buffer)
        begin
            if (lex_mode == MODE_STR || lex_mode == MODE_ESC ||
                lex_mode == MODE_HEX1 || lex_mode == MODE_HEX2)
            begin
                tok[n++] = make_token(KIND_ERROR, 8'h00, ERR_UNCLOSED);
            end
            lex_mode = MODE_OUT;
            hex_hi   = 4'd0;
            line_cnt = 16'd1;
        end
        if (n > 0)
        begin
            tok[n - 1].last_of_run = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            exp_tokens = {exp_tokens, tok[i]};
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin : token_check
        out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            tokens_seen++;
            if (result.kind == KIND_ERROR)
            begin
                lex_errs_seen++;
            end
            if (exp_tokens.size() == 0)
            begin
                $display("%0t: unexpected token, expected none, actual %h", $time, result);
                fails++;
            end
            else
            begin
                want = exp_tokens.pop_front();
                check_field("kind", 16'(want.kind), 16'(result.kind));
                check_field("value", 16'(want.value), 16'(result.value));
                check_field("err_code", 16'(want.err_code), 16'(result.err_code));
                check_field("line_number", want.line_number, result.line_number);
                check_field("last_of_run", 16'(want.last_of_run), 16'(result.last_of_run));
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eob);
        in_item_t it;
        it.in_byte       = b;
        it.end_of_buffer = eob;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        predict_tokens(it);
        bytes_sent++;
        if (eob)
        begin
            buffers_sent++;
        end
    endtask

    task automatic send_text(input string s, input logic eob_last);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], eob_last && (i == s.len() - 1));
        end
    endtask

    // hold the sender off until every expected token has come back
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (exp_tokens.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic test_tokens();
        send_text("{", 1'b0);
        send_byte(8'h00, 1'b0);
        send_text("A\n", 1'b0);
        send_byte(8'hff, 1'b0);
        send_text("}", 1'b1);
        wait_drained();
    endtask

    task automatic test_escapes();
        // valid hex escape, then one with a non-hex digit that swallows a quote
        send_text("\"a\\t\\n\\r\\b\\q\\x4F\\xG\"\\xa7\"", 1'b1);
        wait_drained();
    endtask

    task automatic test_string_errors();
        send_text("{\"ab\n{\"x\"", 1'b1);
        send_text("\n\"c\015}", 1'b1);
        send_text("\"", 1'b1);
        send_text("\"d\\", 1'b1);
        send_text("\"\\x", 1'b1);
        send_text("\"\\x4", 1'b1);
        send_text("\"\\x41", 1'b1);
        wait_drained();
    endtask

    task automatic test_line_count();
        for (int i = 0; i < 250; i++)
        begin
            send_byte(CH_LF, 1'b0);
        end
        send_text("\"z\"\n", 1'b1);
        wait_drained();
    endtask

    function automatic logic [7:0] pick_hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        if ($urandom_range(3) == 0)
        begin
            return 8'($urandom_range(255));
        end
        return digits[$urandom_range(21)];
    endfunction

    function automatic logic [7:0] pick_plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if (c == CH_QUOTE || c == CH_BSLASH || c == CH_LF || c == CH_CR)
        begin
            c = "_";
        end
        return c;
    endfunction

    // mostly well-formed text: braces, newlines, strings with escapes, some noise
    task automatic send_random_buffer();
        logic [7:0] text_q[$];
        int         ntok;
        int         nch;
        logic       cut_short;
        ntok      = $urandom_range(1, 12);
        cut_short = 1'b0;
        for (int t = 0; t < ntok && !cut_short; t++)
        begin
            case ($urandom_range(9))
                0:    text_q = {text_q, CH_LBRACE};
                1:    text_q = {text_q, CH_RBRACE};
                2, 3: text_q = {text_q, CH_LF};
                4:    text_q = {text_q, 8'($urandom_range(255))};
                default:
                begin
                    text_q = {text_q, CH_QUOTE};
                    nch = $urandom_range(0, 6);
                    for (int i = 0; i < nch; i++)
                    begin
                        case ($urandom_range(7))
                            0:
                            begin
                                text_q = {text_q, CH_BSLASH};
                                case ($urandom_range(3))
                                    0:       text_q = {text_q, CH_LOW_T};
                                    1:       text_q = {text_q, CH_LOW_N};
                                    2:       text_q = {text_q, CH_LOW_R};
                                    default: text_q = {text_q, CH_LOW_B};
                                endcase
                            end
                            1:
                            begin
                                text_q = {text_q, CH_BSLASH, CH_LOW_X};
                                text_q = {text_q, pick_hex_char()};
                                text_q = {text_q, pick_hex_char()};
                            end
                            2:
                            begin
                                text_q = {text_q, CH_BSLASH};
                                text_q = {text_q, 8'($urandom_range(255))};
                            end
                            default: text_q = {text_q, pick_plain_char()};
                        endcase
                    end
                    if ($urandom_range(9) == 0)
                    begin
                        case ($urandom_range(3))
                            0: text_q = {text_q, CH_LF};
                            1: text_q = {text_q, CH_CR};
                            2: cut_short = 1'b1;
                            default:
                            begin
                                text_q = {text_q, CH_BSLASH};
                                if ($urandom_range(1))
                                begin
                                    text_q = {text_q, CH_LOW_X};
                                    if ($urandom_range(1))
                                    begin
                                        text_q = {text_q, pick_hex_char()};
                                    end
                                end
                                cut_short = 1'b1;
                            end
                        endcase
                    end
                    if (!cut_short)
                    begin
                        text_q = {text_q, CH_QUOTE};
                    end
                end
            endcase
        end
        for (int i = 0; i < text_q.size(); i++)
        begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
    endtask

    task automatic test_random();
        int idle_pct [4];
        int hold_pct [4];
        int start;
        idle_pct = '{0, 82, 0, 36};
        hold_pct = '{0, 0, 82, 36};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_pct[p];
            stall_pct     = hold_pct[p];
            start         = bytes_sent;
            while (bytes_sent - start < 340)
            begin
                send_random_buffer();
            end
            wait_drained();
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_tokens();
        test_escapes();
        test_string_errors();
        test_line_count();
        test_random();
        item_valid <= 1'b0;
        while (exp_tokens.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        $display("lexed %0d bytes in %0d buffers, %0d tokens checked, %0d of them errors",
                 bytes_sent, buffers_sent, tokens_seen, lex_errs_seen);
        $display("idle and stall mixes applied, line counter walked over a few hundred lines");
        if (fails == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #10000000;
        $display("timeout with %0d tokens outstanding", exp_tokens.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
